// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [7:0] REC_DATA     = 8'h00;
   localparam logic [7:0] REC_EOF      = 8'h01;
   localparam logic [7:0] REC_EXT_SEG  = 8'h02;
   localparam logic [7:0] REC_EXT_LIN  = 8'h04;

   typedef enum logic [3:0] {
      PH_COLON  = 4'd0,
      PH_LENGTH = 4'd1,
      PH_OFFSET = 4'd2,
      PH_TYPE   = 4'd3,
      PH_DATA   = 4'd4,
      PH_EXT    = 4'd5,
      PH_CHECK  = 4'd6,
      PH_HALT   = 4'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_EOF    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_INVALID  = 3'd1,
      ERR_CHECKSUM = 3'd2,
      ERR_TYPE     = 3'd3,
      ERR_EARLY    = 3'd4
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] byte_address;
      logic [7:0]  data_byte;
      err_type     error_code;
      logic [15:0] record_number;
      logic [7:0]  record_type;
      logic [7:0]  computed_sum;
      logic [7:0]  record_sum;
   } rsp_type;

   // no validation: anything past 'F' is taken as a lower-case digit
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else if (c <= CHAR_UPPER_F) begin
         v = c - CHAR_UPPER_A + 8'd10;
      end else begin
         v = c - CHAR_LOWER_A + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// ===== rtl/ihex_decode.sv =====
module ihex_decode import ihex_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] character,
   input  logic       end_of_input,
   output logic       result_valid,
   output rsp_type    result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        nibble_second_ff, nibble_second_in;
   logic [1:0]  field_byte_count_ff, field_byte_count_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [7:0]  data_index_ff, data_index_in;
   logic [15:0] offset_address_ff, offset_address_in;
   logic [7:0]  type_byte_ff, type_byte_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] extension_value_ff, extension_value_in;
   logic [31:0] base_address_ff, base_address_in;
   logic [15:0] records_done_ff, records_done_in;
   logic        stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_COLON;
         high_nibble_ff      <= '0;
         nibble_second_ff    <= 1'b0;
         field_byte_count_ff <= '0;
         record_length_ff    <= '0;
         data_index_ff       <= '0;
         offset_address_ff   <= '0;
         type_byte_ff        <= '0;
         running_sum_ff      <= '0;
         extension_value_ff  <= '0;
         base_address_ff     <= '0;
         records_done_ff     <= '0;
         stopped_ff          <= 1'b0;
      end else if (accept) begin
         phase_ff            <= phase_in;
         high_nibble_ff      <= high_nibble_in;
         nibble_second_ff    <= nibble_second_in;
         field_byte_count_ff <= field_byte_count_in;
         record_length_ff    <= record_length_in;
         data_index_ff       <= data_index_in;
         offset_address_ff   <= offset_address_in;
         type_byte_ff        <= type_byte_in;
         running_sum_ff      <= running_sum_in;
         extension_value_ff  <= extension_value_in;
         base_address_ff     <= base_address_in;
         records_done_ff     <= records_done_in;
         stopped_ff          <= stopped_in;
      end
   end

   always_comb begin
      logic [7:0] b;
      logic [7:0] comp;
      logic [1:0] count_next;
      logic [8:0] index_next;
      logic       space;
      logic       fail;
      err_type    code;

      phase_in            = phase_ff;
      high_nibble_in      = high_nibble_ff;
      nibble_second_in    = nibble_second_ff;
      field_byte_count_in = field_byte_count_ff;
      record_length_in    = record_length_ff;
      data_index_in       = data_index_ff;
      offset_address_in   = offset_address_ff;
      type_byte_in        = type_byte_ff;
      running_sum_in      = running_sum_ff;
      extension_value_in  = extension_value_ff;
      base_address_in     = base_address_ff;
      records_done_in     = records_done_ff;
      stopped_in          = stopped_ff;

      b          = {high_nibble_ff, hex_value(character)};
      comp       = 8'd0 - running_sum_ff;
      count_next = field_byte_count_ff + 2'd1;
      index_next = {1'b0, data_index_ff} + 9'd1;
      space      = (character == CHAR_SPACE) ||
                   ((character >= CHAR_TAB) && (character <= CHAR_CR));
      fail       = 1'b0;
      code       = ERR_NONE;

      result_valid        = 1'b0;
      result              = '0;
      result.kind         = KIND_DATA;
      result.error_code   = ERR_NONE;

      if (stopped_ff) begin
         result_valid = 1'b0;
      end else if (end_of_input) begin
         fail = 1'b1;
         code = ERR_EARLY;
      end else if (phase_ff == PH_COLON) begin
         if (!space) begin
            if (character != CHAR_COLON) begin
               fail = 1'b1;
               code = ERR_INVALID;
            end else begin
               phase_in            = PH_LENGTH;
               high_nibble_in      = '0;
               nibble_second_in    = 1'b0;
               field_byte_count_in = '0;
               record_length_in    = '0;
               data_index_in       = '0;
               offset_address_in   = '0;
               type_byte_in        = '0;
               running_sum_in      = '0;
               extension_value_in  = '0;
            end
         end
      end else if (!nibble_second_ff) begin
         high_nibble_in   = hex_value(character);
         nibble_second_in = 1'b1;
      end else begin
         nibble_second_in = 1'b0;
         if (phase_ff != PH_CHECK) begin
            running_sum_in = running_sum_ff + b;
         end
         unique case (phase_ff)
            PH_LENGTH: begin
               record_length_in    = b;
               field_byte_count_in = '0;
               phase_in            = PH_OFFSET;
            end
            PH_OFFSET: begin
               offset_address_in   = {offset_address_ff[7:0], b};
               field_byte_count_in = count_next;
               if (count_next >= 2'd2) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_byte_in = b;
               if (b == REC_DATA) begin
                  data_index_in = '0;
                  phase_in = (record_length_ff == 8'd0) ? PH_CHECK : PH_DATA;
               end else if (b == REC_EOF) begin
                  stopped_in   = 1'b1;
                  phase_in     = PH_HALT;
                  result_valid = 1'b1;
                  result.kind  = KIND_EOF;
               end else if (b == REC_EXT_SEG || b == REC_EXT_LIN) begin
                  if (record_length_ff != 8'd2) begin
                     fail = 1'b1;
                     code = ERR_INVALID;
                  end else begin
                     field_byte_count_in = '0;
                     extension_value_in  = '0;
                     phase_in            = PH_EXT;
                  end
               end else begin
                  fail = 1'b1;
                  code = ERR_TYPE;
               end
            end
            PH_DATA: begin
               data_index_in = index_next[7:0];
               if (index_next >= {1'b0, record_length_ff}) begin
                  phase_in = PH_CHECK;
               end
               result_valid        = 1'b1;
               result.kind         = KIND_DATA;
               result.byte_address = base_address_ff + {16'd0, offset_address_ff}
                                     + {24'd0, data_index_ff};
               result.data_byte    = b;
            end
            PH_EXT: begin
               extension_value_in  = {extension_value_ff[7:0], b};
               field_byte_count_in = count_next;
               if (count_next >= 2'd2) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               result.computed_sum = comp;
               result.record_sum   = b;
               if (b != comp) begin
                  fail = 1'b1;
                  code = ERR_CHECKSUM;
               end else begin
                  if (type_byte_ff == REC_EXT_SEG) begin
                     base_address_in = {12'd0, extension_value_ff, 4'd0};
                  end else if (type_byte_ff == REC_EXT_LIN) begin
                     base_address_in = {extension_value_ff, 16'd0};
                  end
                  if (records_done_ff != 16'hFFFF) begin
                     records_done_in = records_done_ff + 16'd1;
                  end
                  phase_in     = PH_COLON;
                  result_valid = 1'b1;
                  result.kind  = KIND_ACCEPT;
               end
            end
            default: begin
               stopped_in = 1'b1;
               phase_in   = PH_HALT;
            end
         endcase
      end

      if (fail) begin
         stopped_in        = 1'b1;
         phase_in          = PH_HALT;
         result_valid      = 1'b1;
         result.kind       = KIND_ERROR;
         result.error_code = code;
      end

      result.record_number = records_done_in;
      result.record_type   = type_byte_in;
   end

endmodule

// ===== rtl/ihex_skid.sv =====
module ihex_skid import ihex_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         // drain the skid word first so order is kept
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = in_valid;
            skid_in       = in_data;
         end else begin
            out_valid_in = in_valid;
            out_in       = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ===== rtl/intel_hex_record_decoder.sv =====
// Intel HEX record decoder.
// req channel: one text character per word (req_character), or req_end_of_input
// set to mark the end of the stream. rsp channel: at most one result word per
// character: a tentative data byte with its full address, a record accepted,
// end of file, or an error with its code.
// Each result is registered in the result register, or in the skid word while
// rsp stalls. Throughput: one character per cycle while req_ready is high; each
// character is decoded in a single pass from the decoder state registers.
// Stalls: a two-entry output stage (result register plus skid word) lets the
// block keep taking characters while one result waits; req_ready drops only
// when both entries hold results, and rises again once rsp takes one.
// Reset: clears the decoder to wait for a colon with base address and record
// count at zero, and empties the output stage. After end of file or any error
// the block takes characters but gives no further results until reset.
module intel_hex_record_decoder import ihex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_byte_address,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_record_number,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_record_sum
);

   logic    accept;
   logic    result_valid;
   rsp_type result;
   rsp_type rsp_word;

   assign accept = req_valid && req_ready;

   ihex_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .end_of_input (req_end_of_input),
      .result_valid (result_valid),
      .result       (result)
   );

   ihex_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && result_valid),
      .in_data   (result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_word),
      .out_ready (rsp_ready)
   );

   assign rsp_kind          = rsp_word.kind;
   assign rsp_byte_address  = rsp_word.byte_address;
   assign rsp_data_byte     = rsp_word.data_byte;
   assign rsp_error_code    = rsp_word.error_code;
   assign rsp_record_number = rsp_word.record_number;
   assign rsp_record_type   = rsp_word.record_type;
   assign rsp_computed_sum  = rsp_word.computed_sum;
   assign rsp_record_sum    = rsp_word.record_sum;

endmodule

// ===== rtl/ihex_checker.sv =====
module ihex_checker import ihex_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [2:0]  rsp_error_code,
   input logic [7:0]  rsp_computed_sum,
   input logic [7:0]  rsp_record_sum
);

   // nothing may follow the final word of a stream
   a_final_word_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_EOF || rsp_kind == KIND_ERROR)
      |=> !rsp_valid)
      else $error("result word after end of file or error");

   a_code_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code disagrees with kind");

   a_data_no_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |->
      rsp_computed_sum == 8'd0 && rsp_record_sum == 8'd0)
      else $error("checksum fields set on a data word");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind intel_hex_record_decoder ihex_checker u_ihex_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_error_code   (rsp_error_code),
   .rsp_computed_sum (rsp_computed_sum),
   .rsp_record_sum   (rsp_record_sum)
);
